FILE: src/assert_macros.svh
// Assertion macros used by dnsecs_out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check with active-low reset masking.
`define DNSECS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("dnsecs assertion failed");

// Same, written as antecedent and consequent.
`define DNSECS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dnsecs implication failed");

`endif

FILE: src/dnsecs_pkg.sv
// ----------------------------------------------------------------------------
// dnsecs_pkg
// Types and constants of the client subnet extractor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dnsecs_pkg;

    localparam int MaxPacketBytes = 4096;
    localparam int AddressBytes   = 16;

    localparam logic [15:0] HdrLen     = 16'd12;
    localparam logic [7:0]  PtrBits    = 8'hC0;
    localparam logic [15:0] OptRtype   = 16'd41;
    localparam logic [15:0] SubnetCode = 16'd8;
    localparam logic [4:0]  AddrCap    = 5'd16;
    localparam logic [4:0]  RrFixed    = 5'd10;
    localparam logic [4:0]  QFixed     = 5'd4;

    localparam logic [1:0] StatusOk    = 2'd0;
    localparam logic [1:0] StatusTrunc = 2'd1;
    localparam logic [1:0] StatusShort = 2'd2;

    typedef enum logic [4:0] {
        PH_HDR,
        PH_LABEL,
        PH_LSKIP,
        PH_PTR,
        PH_FIXED,
        PH_RSKIP,
        PH_OHDR,
        PH_OSKIP,
        PH_EFIX,
        PH_EADDR,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic [1:0]  parse_status;
        logic        opt_present;
        logic        subnet_present;
        logic [15:0] transaction_tag;
        logic [15:0] address_family;
        logic [7:0]  source_prefix;
        logic [7:0]  scope_prefix;
        logic [63:0] address_upper;
        logic [63:0] address_lower;
    } t_result;

endpackage

`default_nettype wire

FILE: src/dnsecs_parse.sv
// ----------------------------------------------------------------------------
// dnsecs_parse
// Per-byte message walker; produces the result word on the last byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dnsecs_parse #(
    parameter int MAX_PACKET_BYTES = dnsecs_pkg::MaxPacketBytes,
    parameter int ADDRESS_BYTES    = dnsecs_pkg::AddressBytes
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_take,
    input  wire  [7:0]            i_data_byte,
    input  wire                   i_end_of_packet,
    output dnsecs_pkg::t_result   o_result
);

    dnsecs_pkg::t_phase r_phase, n_phase;
    logic [15:0] r_pos, n_pos;
    logic [15:0] r_cnt [4];
    logic [15:0] n_cnt [4];
    logic [15:0] r_skip, n_skip;
    logic [4:0]  r_fs, n_fs;
    logic [15:0] r_orem, n_orem;
    logic [15:0] r_ocl0, n_ocl0;
    logic [15:0] r_ocl1, n_ocl1;
    logic [7:0]  r_cap [16];
    logic [7:0]  n_cap [16];
    logic        r_fl_opt, n_fl_opt;
    logic        r_fl_found, n_fl_found;
    logic        r_fl_root, n_fl_root;
    logic [15:0] r_tag, n_tag;
    logic [15:0] r_rtype, n_rtype;
    logic [1:0]  r_sect, n_sect;
    logic [7:0]  r_src, n_src;
    logic [7:0]  r_scope, n_scope;

    always_comb begin
        logic        do_next, do_walk, do_skip;
        logic [15:0] skip_n;
        logic [15:0] len;
        logic [15:0] mn;
        logic [5:0]  need;
        logic [4:0]  lim;
        logic [1:0]  hidx;
        logic        hit;
        dnsecs_pkg::t_result res;
        n_phase = r_phase; n_pos = r_pos; n_skip = r_skip; n_fs = r_fs;
        n_orem = r_orem; n_ocl0 = r_ocl0; n_ocl1 = r_ocl1;
        n_fl_opt = r_fl_opt; n_fl_found = r_fl_found; n_fl_root = r_fl_root;
        n_tag = r_tag; n_rtype = r_rtype; n_sect = r_sect;
        n_src = r_src; n_scope = r_scope;
        n_cnt = r_cnt; n_cap = r_cap;
        do_next = 1'b0; do_walk = 1'b0; do_skip = 1'b0; skip_n = '0;
        len = '0; mn = '0; need = '0; lim = '0; hidx = '0; hit = 1'b0;

        if ({1'b0, r_pos} < 17'(MAX_PACKET_BYTES)) begin
            case (r_phase)
                dnsecs_pkg::PH_HDR: begin
                    if (r_pos < 16'd2) n_tag = {r_tag[7:0], i_data_byte};
                    else if (r_pos >= 16'd4 && r_pos < dnsecs_pkg::HdrLen) begin
                        hidx = 2'((r_pos - 16'd4) >> 1);
                        n_cnt[hidx] = {r_cnt[hidx][7:0], i_data_byte};
                    end
                    if (r_pos == dnsecs_pkg::HdrLen - 16'd1) begin
                        if (n_cnt[3] == 16'd0) n_phase = dnsecs_pkg::PH_DONE;
                        else do_next = 1'b1;
                    end
                end
                dnsecs_pkg::PH_LABEL: begin
                    if (i_data_byte == 8'd0) begin
                        n_phase = dnsecs_pkg::PH_FIXED;
                        n_fs = '0; n_rtype = '0; n_skip = '0;
                    end else begin
                        n_fl_root = 1'b0;
                        if ((i_data_byte & dnsecs_pkg::PtrBits) == dnsecs_pkg::PtrBits) begin
                            n_phase = dnsecs_pkg::PH_PTR;
                        end else begin
                            n_skip  = {8'd0, i_data_byte};
                            n_phase = dnsecs_pkg::PH_LSKIP;
                        end
                    end
                end
                dnsecs_pkg::PH_LSKIP: begin
                    n_skip = r_skip - 16'd1;
                    if (n_skip == 16'd0) n_phase = dnsecs_pkg::PH_LABEL;
                end
                dnsecs_pkg::PH_PTR: begin
                    n_phase = dnsecs_pkg::PH_FIXED;
                    n_fs = '0; n_rtype = '0; n_skip = '0;
                end
                dnsecs_pkg::PH_FIXED: begin
                    if (r_fs < 5'd2) n_rtype = {r_rtype[7:0], i_data_byte};
                    else if (r_fs == 5'd8 || r_fs == 5'd9) n_skip = {r_skip[7:0], i_data_byte};
                    n_fs = r_fs + 5'd1;
                    lim = (r_sect == 2'd0) ? dnsecs_pkg::QFixed : dnsecs_pkg::RrFixed;
                    if (n_fs == lim) begin
                        if (r_sect == 2'd0) do_next = 1'b1;
                        else if (r_sect == 2'd3 && n_rtype == dnsecs_pkg::OptRtype
                                 && r_fl_root) begin
                            n_fl_opt = 1'b1;
                            n_orem   = n_skip;
                            do_walk  = 1'b1;
                        end else begin
                            do_skip = 1'b1; skip_n = n_skip;
                        end
                    end
                end
                dnsecs_pkg::PH_RSKIP: begin
                    n_skip = r_skip - 16'd1;
                    if (n_skip == 16'd0) do_next = 1'b1;
                end
                dnsecs_pkg::PH_OHDR: begin
                    n_orem = r_orem - 16'd1;
                    if (r_fs[1]) n_ocl1 = {r_ocl1[7:0], i_data_byte};
                    else n_ocl0 = {r_ocl0[7:0], i_data_byte};
                    n_fs = r_fs + 5'd1;
                    if (n_fs == 5'd4) begin
                        len = n_ocl1;
                        if (n_ocl0 == dnsecs_pkg::SubnetCode) begin
                            if (len >= 16'd4 && len <= n_orem) begin
                                n_phase = dnsecs_pkg::PH_EFIX;
                                n_fs = '0; n_ocl0 = '0;
                            end else begin
                                do_skip = 1'b1; skip_n = n_orem;
                            end
                        end else begin
                            mn = (len < n_orem) ? len : n_orem;
                            n_orem = n_orem - mn;
                            if (mn == 16'd0) do_walk = 1'b1;
                            else begin
                                n_skip = mn; n_phase = dnsecs_pkg::PH_OSKIP;
                            end
                        end
                    end
                end
                dnsecs_pkg::PH_OSKIP: begin
                    n_skip = r_skip - 16'd1;
                    if (n_skip == 16'd0) do_walk = 1'b1;
                end
                dnsecs_pkg::PH_EFIX: begin
                    if (r_fs < 5'd2) n_ocl0 = {r_ocl0[7:0], i_data_byte};
                    else if (r_fs == 5'd2) n_src = i_data_byte;
                    else n_scope = i_data_byte;
                    n_fs = r_fs + 5'd1;
                    if (n_fs == 5'd4) begin
                        need = 6'(({1'b0, n_src} + 9'd7) >> 3);
                        if (need > {1'b0, dnsecs_pkg::AddrCap})
                            need = {1'b0, dnsecs_pkg::AddrCap};
                        if (need > 6'(ADDRESS_BYTES)) need = 6'(ADDRESS_BYTES);
                        if ({10'd0, need} + 16'd4 > r_ocl1) need = '0;
                        if (need == 6'd0) begin
                            n_fl_found = 1'b1; n_phase = dnsecs_pkg::PH_DONE;
                        end else begin
                            n_skip = {10'd0, need}; n_fs = '0;
                            n_phase = dnsecs_pkg::PH_EADDR;
                        end
                    end
                end
                dnsecs_pkg::PH_EADDR: begin
                    n_cap[r_fs[3:0]] = i_data_byte;
                    n_fs = r_fs + 5'd1;
                    n_skip = r_skip - 16'd1;
                    if (n_skip == 16'd0) begin
                        n_fl_found = 1'b1; n_phase = dnsecs_pkg::PH_DONE;
                    end
                end
                default: ;
            endcase

            if (do_walk) begin
                if (n_orem >= 16'd4) begin
                    n_phase = dnsecs_pkg::PH_OHDR;
                    n_fs = '0; n_ocl0 = '0; n_ocl1 = '0;
                end else begin
                    do_skip = 1'b1; skip_n = n_orem;
                end
            end
            if (do_skip) begin
                if (skip_n == 16'd0) do_next = 1'b1;
                else begin
                    n_skip = skip_n; n_phase = dnsecs_pkg::PH_RSKIP;
                end
            end
            if (do_next) begin
                if (n_fl_found) n_phase = dnsecs_pkg::PH_DONE;
                else begin
                    n_phase = dnsecs_pkg::PH_DONE;
                    for (int s = 0; s < 4; s++) begin
                        if (!hit && n_cnt[s] != 16'd0) begin
                            hit = 1'b1;
                            n_cnt[s] = n_cnt[s] - 16'd1;
                            n_sect = 2'(s);
                            n_fl_root = 1'b1;
                            n_phase = dnsecs_pkg::PH_LABEL;
                            n_fs = '0;
                        end
                    end
                end
            end
        end

        if (r_pos != 16'hFFFF) n_pos = r_pos + 16'd1;

        res = '0;
        if (n_pos < dnsecs_pkg::HdrLen) begin
            res.parse_status = dnsecs_pkg::StatusShort;
        end else begin
            res.parse_status = (n_phase == dnsecs_pkg::PH_DONE) ?
                               dnsecs_pkg::StatusOk : dnsecs_pkg::StatusTrunc;
            res.opt_present     = n_fl_opt;
            res.subnet_present  = n_fl_found;
            res.transaction_tag = n_tag;
            if (n_fl_found) begin
                res.address_family = n_ocl0;
                res.source_prefix  = n_src;
                res.scope_prefix   = n_scope;
                for (int k = 0; k < 8; k++) begin
                    res.address_upper[63 - 8*k -: 8] = n_cap[k];
                    res.address_lower[63 - 8*k -: 8] = n_cap[k + 8];
                end
            end
        end
        o_result = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_end_of_packet)) begin
            r_phase <= dnsecs_pkg::PH_HDR;
            r_pos <= '0; r_skip <= '0; r_fs <= '0; r_orem <= '0;
            r_ocl0 <= '0; r_ocl1 <= '0;
            r_fl_opt <= 1'b0; r_fl_found <= 1'b0; r_fl_root <= 1'b0;
            r_tag <= '0; r_rtype <= '0; r_sect <= '0; r_src <= '0; r_scope <= '0;
            for (int s = 0; s < 4; s++) r_cnt[s] <= '0;
            for (int k = 0; k < 16; k++) r_cap[k] <= '0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_pos <= n_pos; r_skip <= n_skip; r_fs <= n_fs; r_orem <= n_orem;
            r_ocl0 <= n_ocl0; r_ocl1 <= n_ocl1;
            r_fl_opt <= n_fl_opt; r_fl_found <= n_fl_found; r_fl_root <= n_fl_root;
            r_tag <= n_tag; r_rtype <= n_rtype; r_sect <= n_sect;
            r_src <= n_src; r_scope <= n_scope;
            r_cnt <= n_cnt;
            r_cap <= n_cap;
        end
    end

endmodule

`default_nettype wire

FILE: src/dnsecs_out.sv
// ----------------------------------------------------------------------------
// dnsecs_out
// Result register with valid/stall handshake toward the consumer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dnsecs_out (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_load,
    input  dnsecs_pkg::t_result  i_result,
    input  wire                  i_stall,
    output logic                 o_valid,
    output logic                 o_busy,
    output dnsecs_pkg::t_result  o_result
);

    logic                r_valid;
    dnsecs_pkg::t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_busy   = r_valid && i_stall;
    assign o_result = r_result;

    `DNSECS_ASSERT(a_hold, i_clk, i_rst_n, r_valid && i_stall |=> r_valid)
    `DNSECS_ASSERT_IMP(a_found_ok, i_clk, i_rst_n, r_valid && r_result.subnet_present, r_result.parse_status == dnsecs_pkg::StatusOk && r_result.opt_present)
    `DNSECS_ASSERT_IMP(a_short, i_clk, i_rst_n, r_valid && r_result.parse_status == dnsecs_pkg::StatusShort, !r_result.opt_present && r_result.transaction_tag == 16'd0)

endmodule

`default_nettype wire

FILE: src/dns_edns_client_subnet_extract_core.sv
// ----------------------------------------------------------------------------
// dns_edns_client_subnet_extract_core
// Streams a DNS message byte by byte and reports its EDNS client subnet.
// ----------------------------------------------------------------------------
// One byte is taken per cycle unless the input is stalled; each byte updates
// the walker state registers, and the last byte of a message loads the result
// register, so the block sustains one byte per clock while not stalled. The input
// stalls only while a result waits in the result register and the consumer stalls it.
`timescale 1ns / 1ps
`default_nettype none

module dns_edns_client_subnet_extract_core #(
    parameter int MAX_PACKET_BYTES = dnsecs_pkg::MaxPacketBytes,
    parameter int ADDRESS_BYTES    = dnsecs_pkg::AddressBytes
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [7:0]  i_data_byte,
    input  wire         i_end_of_packet,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [1:0]  o_parse_status,
    output logic        o_opt_present,
    output logic        o_subnet_present,
    output logic [15:0] o_transaction_tag,
    output logic [15:0] o_address_family,
    output logic [7:0]  o_source_prefix,
    output logic [7:0]  o_scope_prefix,
    output logic [63:0] o_address_upper,
    output logic [63:0] o_address_lower
);

    logic                busy;
    logic                take;
    dnsecs_pkg::t_result res_next;
    dnsecs_pkg::t_result res_out;

    assign take    = i_valid && !busy;
    assign o_stall = busy;

    dnsecs_parse #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
        .ADDRESS_BYTES    (ADDRESS_BYTES)
    ) u_parse (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (take),
        .i_data_byte     (i_data_byte),
        .i_end_of_packet (i_end_of_packet),
        .o_result        (res_next)
    );

    dnsecs_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (take && i_end_of_packet),
        .i_result (res_next),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_busy   (busy),
        .o_result (res_out)
    );

    assign o_parse_status    = res_out.parse_status;
    assign o_opt_present     = res_out.opt_present;
    assign o_subnet_present  = res_out.subnet_present;
    assign o_transaction_tag = res_out.transaction_tag;
    assign o_address_family  = res_out.address_family;
    assign o_source_prefix   = res_out.source_prefix;
    assign o_scope_prefix    = res_out.scope_prefix;
    assign o_address_upper   = res_out.address_upper;
    assign o_address_lower   = res_out.address_lower;

endmodule

`default_nettype wire
